/* rtl/qvie_pkg.sv */
// shared types, codes and constants of the quad vertex index emitter
`default_nettype none
package qvie_pkg;

	localparam int VERTEX_CAPACITY = 65536;
	localparam int VC_W = $clog2(VERTEX_CAPACITY + 5);

	// result kinds
	localparam logic [1:0] KIND_VERTEX = 2'd0;
	localparam logic [1:0] KIND_INDEX  = 2'd1;
	localparam logic [1:0] KIND_BATCH  = 2'd2;
	localparam logic [1:0] KIND_DROP   = 2'd3;

	// shade modes
	localparam logic [1:0] SHADE_FILL = 2'd2;

	// input modes
	localparam logic MODE_FLUSH = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_MAT_XX  = 3'd0;
	localparam logic [2:0] REG_MAT_XY  = 3'd1;
	localparam logic [2:0] REG_MAT_YX  = 3'd2;
	localparam logic [2:0] REG_MAT_YY  = 3'd3;
	localparam logic [2:0] REG_MAT_TX  = 3'd4;
	localparam logic [2:0] REG_MAT_TY  = 3'd5;
	localparam logic [2:0] REG_SHADE   = 3'd6;
	localparam logic [2:0] REG_DEF_TEX = 3'd7;

	// emitter steps within one request
	localparam logic [2:0] STEP_BATCH    = 3'd0;
	localparam logic [2:0] STEP_VERTEX   = 3'd1;
	localparam logic [2:0] STEP_IDX_LAST = 3'd7;

	typedef struct packed {
		logic signed [31:0] xx;
		logic signed [31:0] xy;
		logic signed [31:0] yx;
		logic signed [31:0] yy;
		logic signed [31:0] tx;
		logic signed [31:0] ty;
	} mat_t;

	// everything one request will emit, apart from the position math
	typedef struct packed {
		logic        has_batch;
		logic [14:0] b_off;
		logic [15:0] b_cnt;
		logic [15:0] b_tex;
		logic        is_corner;
		logic        drop;
		logic        has_index;
		logic [15:0] base;
		logic [15:0] u;
		logic [15:0] v;
		logic [31:0] color;
		logic [1:0]  shade;
	} job_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] x;
		logic [31:0] y;
		logic [15:0] u;
		logic [15:0] v;
		logic [31:0] color;
		logic [1:0]  shade;
		logic [15:0] index;
		logic [14:0] b_off;
		logic [15:0] b_cnt;
		logic [15:0] b_tex;
		logic        last;
	} res_t;

	// corner offset of the six triangle-list indices (0,1,2,0,2,3)
	function automatic logic [1:0] idx_offset(input logic [2:0] step);
		logic [1:0] r;
		unique case (step)
			3'd3:    r = 2'd1;
			3'd4:    r = 2'd2;
			3'd6:    r = 2'd2;
			3'd7:    r = 2'd3;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/qvie_seq.sv */
// quad sequencer: corner, capacity and batch state, first pipeline register
`default_nettype none
module qvie_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                mode,
	input  wire logic                solid,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic [15:0]         tex_u,
	input  wire logic [15:0]         tex_v,
	input  wire logic [31:0]         color,
	input  wire logic [15:0]         texture,
	input  wire logic [1:0]          shade_mode,
	input  wire logic [15:0]         solid_tex,
	output logic                     s1_valid,
	input  wire logic                s1_ready,
	output qvie_pkg::job_t           job_s1,
	output logic signed [31:0]       x_s1,
	output logic signed [31:0]       y_s1
);

	logic [1:0]                corner_q;
	logic [qvie_pkg::VC_W-1:0] vcount_q;
	logic [15:0]               base_q;
	logic [15:0]               open_off_q;
	logic [15:0]               open_cnt_q;
	logic [15:0]               open_tex_q;
	logic                      dropping_q;
	logic                      s1_valid_q;

	logic [1:0]                corner_d;
	logic [qvie_pkg::VC_W-1:0] vcount_d;
	logic [15:0]               base_d;
	logic [15:0]               open_off_d;
	logic [15:0]               open_cnt_d;
	logic [15:0]               open_tex_d;
	logic                      dropping_d;
	logic [15:0]               tex;
	logic                      full;
	logic                      drop;
	logic [1:0]                shade_sat;
	logic                      accept;
	qvie_pkg::job_t            job;

	assign in_ready = !s1_valid_q || s1_ready;
	assign accept   = in_valid && in_ready;
	assign s1_valid = s1_valid_q;

	assign tex       = solid ? solid_tex : texture;
	assign full      = ((qvie_pkg::VC_W + 1)'(vcount_q) + (qvie_pkg::VC_W + 1)'(4)) >
	                   (qvie_pkg::VC_W + 1)'(qvie_pkg::VERTEX_CAPACITY);
	assign shade_sat = (shade_mode > qvie_pkg::SHADE_FILL) ? qvie_pkg::SHADE_FILL : shade_mode;

	always_comb begin
		corner_d   = corner_q;
		vcount_d   = vcount_q;
		base_d     = base_q;
		open_off_d = open_off_q;
		open_cnt_d = open_cnt_q;
		open_tex_d = open_tex_q;
		dropping_d = dropping_q;
		drop       = dropping_q;

		job           = '0;
		job.b_off     = open_off_q[14:0];
		job.b_cnt     = open_cnt_q;
		job.b_tex     = open_tex_q;
		job.u         = solid ? 16'd0 : tex_u;
		job.v         = solid ? 16'd0 : tex_v;
		job.color     = color;
		job.shade     = solid ? qvie_pkg::SHADE_FILL : shade_sat;

		if (mode == qvie_pkg::MODE_FLUSH) begin
			job.has_batch = (open_cnt_q != 16'd0);
			corner_d      = 2'd0;
			vcount_d      = '0;
			dropping_d    = 1'b0;
			open_off_d    = 16'd0;
			open_cnt_d    = 16'd0;
			open_tex_d    = 16'd0;
		end else begin
			if (corner_q == 2'd0) begin
				drop = full;
				if (!full) begin
					if (open_cnt_q == 16'd0) begin
						open_tex_d = tex;
					end else if (open_tex_q != tex) begin
						job.has_batch = 1'b1;
						open_off_d    = open_off_q + open_cnt_q;
						open_tex_d    = tex;
					end
					base_d     = 16'(vcount_q);
					vcount_d   = vcount_q + qvie_pkg::VC_W'(4);
					open_cnt_d = (job.has_batch ? 16'd0 : open_cnt_q) + 16'd2;
				end
			end
			job.is_corner = 1'b1;
			job.drop      = drop;
			job.has_index = !drop && (corner_q == 2'd3);
			dropping_d    = (corner_q == 2'd3) ? 1'b0 : drop;
			corner_d      = corner_q + 2'd1;
		end
		job.base = base_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q   <= 2'd0;
			vcount_q   <= '0;
			base_q     <= 16'd0;
			open_off_q <= 16'd0;
			open_cnt_q <= 16'd0;
			open_tex_q <= 16'd0;
			dropping_q <= 1'b0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				corner_q   <= corner_d;
				vcount_q   <= vcount_d;
				base_q     <= base_d;
				open_off_q <= open_off_d;
				open_cnt_q <= open_cnt_d;
				open_tex_q <= open_tex_d;
				dropping_q <= dropping_d;
			end
			if (in_ready) begin
				s1_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job;
			x_s1   <= pos_x;
			y_s1   <= pos_y;
		end
	end

endmodule
`default_nettype wire

/* rtl/qvie_xform.sv */
// affine multiply stage: four registered 32x32 signed products
`default_nettype none
module qvie_xform (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire qvie_pkg::mat_t     mat,
	input  wire logic               s1_valid,
	output logic                    s1_ready,
	input  wire qvie_pkg::job_t     job_s1,
	input  wire logic signed [31:0] x_s1,
	input  wire logic signed [31:0] y_s1,
	output logic                    s2_valid,
	input  wire logic               s2_ready,
	output qvie_pkg::job_t          job_s2,
	output logic signed [63:0]      pxa_s2,
	output logic signed [63:0]      pxb_s2,
	output logic signed [63:0]      pya_s2,
	output logic signed [63:0]      pyb_s2
);

	logic s2_valid_q;
	logic load;

	assign s1_ready = !s2_valid_q || s2_ready;
	assign load     = s1_valid && s1_ready;
	assign s2_valid = s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s1_ready) begin
			s2_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s2 <= job_s1;
			pxa_s2 <= $signed(mat.xx) * $signed(x_s1);
			pxb_s2 <= $signed(mat.yx) * $signed(y_s1);
			pya_s2 <= $signed(mat.xy) * $signed(x_s1);
			pyb_s2 <= $signed(mat.yy) * $signed(y_s1);
		end
	end

endmodule
`default_nettype wire

/* rtl/qvie_emit.sv */
// rounding sum stage and result sequencer feeding the output register
`default_nettype none
module qvie_emit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic signed [31:0] mat_tx,
	input  wire logic signed [31:0] mat_ty,
	input  wire logic               s2_valid,
	output logic                    s2_ready,
	input  wire qvie_pkg::job_t     job_s2,
	input  wire logic signed [63:0] pxa_s2,
	input  wire logic signed [63:0] pxb_s2,
	input  wire logic signed [63:0] pya_s2,
	input  wire logic signed [63:0] pyb_s2,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output qvie_pkg::res_t          out_res
);

	logic               s3_valid_q;
	qvie_pkg::job_t     job_s3;
	logic [31:0]        x_s3;
	logic [31:0]        y_s3;
	logic [2:0]         step_q;
	logic               out_valid_q;
	qvie_pkg::res_t     res_q;

	logic signed [65:0] sum_x;
	logic signed [65:0] sum_y;
	logic [2:0]         last_step;
	logic               empty;
	logic               out_free;
	logic               emit;
	logic               done;
	logic               load;
	qvie_pkg::res_t     res;

	// floor of the rounded sum, clamped to the signed 32-bit range
	function automatic logic [31:0] sat32(input logic signed [65:0] s);
		logic [49:0] h;
		logic [31:0] r;
		h = s[65:16];
		if (h[49:31] == {19{h[49]}}) begin
			r = h[31:0];
		end else if (h[49]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

	assign sum_x = 66'(pxa_s2) + 66'(pxb_s2) + 66'($signed({mat_tx, 16'h0000})) + 66'sd32768;
	assign sum_y = 66'(pya_s2) + 66'(pyb_s2) + 66'($signed({mat_ty, 16'h0000})) + 66'sd32768;

	assign empty     = !job_s3.has_batch && !job_s3.is_corner;
	assign last_step = !job_s3.is_corner ? qvie_pkg::STEP_BATCH :
	                   job_s3.has_index   ? qvie_pkg::STEP_IDX_LAST : qvie_pkg::STEP_VERTEX;
	assign out_free  = !out_valid_q || out_ready;
	assign emit      = s3_valid_q && !empty && out_free;
	assign done      = s3_valid_q && (empty || (emit && step_q == last_step));
	assign s2_ready  = !s3_valid_q || done;
	assign load      = s2_valid && s2_ready;

	always_comb begin
		res      = '0;
		res.last = (step_q == last_step);
		priority if (step_q == qvie_pkg::STEP_BATCH) begin
			res.kind  = qvie_pkg::KIND_BATCH;
			res.b_off = job_s3.b_off;
			res.b_cnt = job_s3.b_cnt;
			res.b_tex = job_s3.b_tex;
		end else if (step_q == qvie_pkg::STEP_VERTEX) begin
			if (job_s3.drop) begin
				res.kind = qvie_pkg::KIND_DROP;
			end else begin
				res.kind  = qvie_pkg::KIND_VERTEX;
				res.x     = x_s3;
				res.y     = y_s3;
				res.u     = job_s3.u;
				res.v     = job_s3.v;
				res.color = job_s3.color;
				res.shade = job_s3.shade;
			end
		end else begin
			res.kind  = qvie_pkg::KIND_INDEX;
			res.index = job_s3.base + 16'(qvie_pkg::idx_offset(step_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q  <= 1'b0;
			step_q      <= qvie_pkg::STEP_BATCH;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_ready) begin
				s3_valid_q <= s2_valid;
			end
			if (load) begin
				step_q <= job_s2.has_batch ? qvie_pkg::STEP_BATCH : qvie_pkg::STEP_VERTEX;
			end else if (emit && !done) begin
				step_q <= step_q + 3'd1;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s3 <= job_s2;
			x_s3   <= sat32(sum_x);
			y_s3   <= sat32(sum_y);
		end
		if (emit) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

/* rtl/quad_vertex_index_emitter.sv */
// top level of the quad vertex index emitter: ports, configuration registers, pipeline
`default_nettype none
// Quad corners enter on s_axis, one request per cycle while s_axis_tready is high,
// four corners per quad, and flush requests close the open batch. Each corner leaves
// as one vertex (position through the 2x3 Q16.16 affine matrix, rounded half up and
// saturated) or as one drop marker when the quad did not fit the vertex capacity;
// the fourth corner of a quad that fits adds six triangle-list indices, and a texture
// change on a first corner puts a batch record ahead of its vertex. Results leave on
// m_axis one per cycle while m_axis_tready is high, with tlast on the final result
// of each request. The single output register sets the pace: a quad yields 10
// results, 11 with a batch record. A lone request's first result passes the
// sequencer register, multiply stage, sum stage and output register in turn.
// While results wait on m_axis, requests fill the pipeline registers, then s_axis stalls.
// Configuration writes are taken at any time on the cfg port but must only be
// issued while the block holds no request.
module quad_vertex_index_emitter (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// configuration write channel
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	// request input
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [143:0] s_axis_tdata,  // pos_x, pos_y, tex_u, tex_v, color, texture
	input  wire logic [1:0]   s_axis_tuser,  // mode, solid
	// result output
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [199:0]      m_axis_tdata,  // out_x, out_y, out_u, out_v, out_color, shade,
	                                         // index_value, batch_offset, batch_count,
	                                         // batch_texture, zero pad
	output logic [1:0]        m_axis_tuser,  // kind
	output logic              m_axis_tlast
);

	qvie_pkg::mat_t     mat_q;
	logic [1:0]         shade_q;
	logic [15:0]        def_tex_q;

	logic               s1_valid;
	logic               s1_ready;
	qvie_pkg::job_t     job_s1;
	logic signed [31:0] x_s1;
	logic signed [31:0] y_s1;

	logic               s2_valid;
	logic               s2_ready;
	qvie_pkg::job_t     job_s2;
	logic signed [63:0] pxa_s2;
	logic signed [63:0] pxb_s2;
	logic signed [63:0] pya_s2;
	logic signed [63:0] pyb_s2;

	qvie_pkg::res_t     res;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q.xx  <= 32'sh0001_0000;
			mat_q.xy  <= 32'sh0;
			mat_q.yx  <= 32'sh0;
			mat_q.yy  <= 32'sh0001_0000;
			mat_q.tx  <= 32'sh0;
			mat_q.ty  <= 32'sh0;
			shade_q   <= 2'd0;
			def_tex_q <= 16'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				qvie_pkg::REG_MAT_XX:  mat_q.xx  <= cfg_data;
				qvie_pkg::REG_MAT_XY:  mat_q.xy  <= cfg_data;
				qvie_pkg::REG_MAT_YX:  mat_q.yx  <= cfg_data;
				qvie_pkg::REG_MAT_YY:  mat_q.yy  <= cfg_data;
				qvie_pkg::REG_MAT_TX:  mat_q.tx  <= cfg_data;
				qvie_pkg::REG_MAT_TY:  mat_q.ty  <= cfg_data;
				qvie_pkg::REG_SHADE:   shade_q   <= cfg_data[1:0];
				qvie_pkg::REG_DEF_TEX: def_tex_q <= cfg_data[15:0];
				default:               def_tex_q <= def_tex_q;
			endcase
		end
	end

	// corner / batch bookkeeping and first register
	qvie_seq u_seq (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.mode            (s_axis_tuser[0]),
		.solid           (s_axis_tuser[1]),
		.pos_x           (s_axis_tdata[31:0]),
		.pos_y           (s_axis_tdata[63:32]),
		.tex_u           (s_axis_tdata[79:64]),
		.tex_v           (s_axis_tdata[95:80]),
		.color           (s_axis_tdata[127:96]),
		.texture         (s_axis_tdata[143:128]),
		.shade_mode      (shade_q),
		.solid_tex       (def_tex_q),
		.s1_valid        (s1_valid),
		.s1_ready        (s1_ready),
		.job_s1          (job_s1),
		.x_s1            (x_s1),
		.y_s1            (y_s1)
	);

	// matrix products
	qvie_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.mat      (mat_q),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.job_s1   (job_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.s2_valid (s2_valid),
		.s2_ready (s2_ready),
		.job_s2   (job_s2),
		.pxa_s2   (pxa_s2),
		.pxb_s2   (pxb_s2),
		.pya_s2   (pya_s2),
		.pyb_s2   (pyb_s2)
	);

	// rounding, saturation and one result per cycle out while m_axis_tready is high
	qvie_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_tx    (mat_q.tx),
		.mat_ty    (mat_q.ty),
		.s2_valid  (s2_valid),
		.s2_ready  (s2_ready),
		.job_s2    (job_s2),
		.pxa_s2    (pxa_s2),
		.pxb_s2    (pxb_s2),
		.pya_s2    (pya_s2),
		.pyb_s2    (pyb_s2),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	// result packing, lowest field first
	assign m_axis_tdata = {7'd0, res.b_tex, res.b_cnt, res.b_off, res.index, res.shade,
	                       res.color, res.v, res.u, res.y, res.x};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

/* test/qvie_check.sv */
// request/result checker for the quad vertex index emitter: predicts and compares results
module qvie_check (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [143:0] s_axis_tdata,  // pos_x, pos_y, tex_u, tex_v, color, texture
	input  wire logic [1:0]   s_axis_tuser,  // mode, solid
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [199:0] m_axis_tdata,  // out_x, out_y, out_u, out_v, out_color, shade,
	                                         // index_value, batch_offset, batch_count,
	                                         // batch_texture, zero pad
	input  wire logic [1:0]   m_axis_tuser,  // kind
	input  wire logic         m_axis_tlast,
	output int                owed_count,
	output int                mismatches
);

	// shadow of the configuration registers
	qvie_pkg::mat_t mat;
	logic [1:0]     shade_reg;
	logic [15:0]    def_texture;

	// shadow of the batching state
	logic [1:0]  corner;
	int          vcount;
	logic [15:0] quad_base;
	logic [15:0] open_offset;
	logic [15:0] open_elements;
	logic [15:0] open_texture;
	logic        dropping;

	qvie_pkg::res_t awaited_results[$];

	initial begin
		owed_count = 0;
		mismatches = 0;
	end

	// x*a + y*b + t, rounded half up to Q16.16 and saturated
	function automatic logic [31:0] affine_q16(input logic signed [31:0] ca, cb, ct, x, y);
		logic signed [95:0] wa, wb, wt, wx, wy, acc;
		wa = ca;
		wb = cb;
		wt = ct;
		wx = x;
		wy = y;
		acc = wa * wx + wb * wy + (wt <<< 16) + 96'sd32768;
		acc = acc >>> 16;
		if (acc > 96'sd2147483647)
			return 32'h7FFF_FFFF;
		if (acc < -96'sd2147483648)
			return 32'h8000_0000;
		return acc[31:0];
	endfunction

	function automatic qvie_pkg::res_t batch_record();
		qvie_pkg::res_t r;
		r = '0;
		r.kind  = qvie_pkg::KIND_BATCH;
		r.b_off = open_offset[14:0];
		r.b_cnt = open_elements;
		r.b_tex = open_texture;
		return r;
	endfunction

	// queue one expected result at the tail
	function automatic void owe(input qvie_pkg::res_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void predict_request(input logic [143:0] d, input logic [1:0] u);
		logic signed [31:0] px, py;
		logic [15:0]    tex;
		logic           solid;
		qvie_pkg::res_t r;
		int             n0;
		px    = d[31:0];
		py    = d[63:32];
		solid = u[1];
		n0    = awaited_results.size();
		if (u[0] == qvie_pkg::MODE_FLUSH) begin
			if (open_elements != 0)
				owe(batch_record());
			corner        = 2'd0;
			vcount        = 0;
			dropping      = 1'b0;
			open_offset   = '0;
			open_elements = '0;
			open_texture  = '0;
		end else begin
			if (corner == 2'd0) begin
				tex = solid ? def_texture : d[143:128];
				if (vcount + 4 > qvie_pkg::VERTEX_CAPACITY) begin
					dropping = 1'b1;
				end else begin
					dropping = 1'b0;
					if (open_elements == 0) begin
						open_texture = tex;
					end else if (open_texture != tex) begin
						// texture change closes the open batch
						owe(batch_record());
						open_offset   = open_offset + open_elements;
						open_elements = '0;
						open_texture  = tex;
					end
					quad_base     = vcount[15:0];
					vcount        = vcount + 4;
					open_elements = open_elements + 16'd2;
				end
			end
			if (dropping) begin
				r = '0;
				r.kind = qvie_pkg::KIND_DROP;
				owe(r);
			end else begin
				r = '0;
				r.kind  = qvie_pkg::KIND_VERTEX;
				r.x     = affine_q16(mat.xx, mat.yx, mat.tx, px, py);
				r.y     = affine_q16(mat.xy, mat.yy, mat.ty, px, py);
				r.u     = solid ? 16'd0 : d[79:64];
				r.v     = solid ? 16'd0 : d[95:80];
				r.color = d[127:96];
				r.shade = solid ? qvie_pkg::SHADE_FILL :
				          (shade_reg > qvie_pkg::SHADE_FILL ? qvie_pkg::SHADE_FILL : shade_reg);
				owe(r);
				if (corner == 2'd3) begin
					// two triangles, each fanning out from the first corner
					for (int t = 0; t < 2; t++) begin
						for (int j = 0; j < 3; j++) begin
							r = '0;
							r.kind  = qvie_pkg::KIND_INDEX;
							r.index = quad_base + (j == 0 ? 16'd0 : 16'(t + j));
							owe(r);
						end
					end
				end
			end
			if (corner == 2'd3)
				dropping = 1'b0;
			corner = corner + 2'd1;
		end
		if (awaited_results.size() > n0) begin
			r = awaited_results[awaited_results.size() - 1];
			r.last = 1'b1;
			awaited_results[awaited_results.size() - 1] = r;
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	function automatic void compare_result();
		qvie_pkg::res_t want;
		if (awaited_results.size() == 0) begin
			mismatches++;
			$display("%0t: result of kind %0d expected none got tdata %h", $time,
				m_axis_tuser, m_axis_tdata);
			return;
		end
		want = awaited_results.pop_front();
		check_field("kind", want.kind, m_axis_tuser);
		check_field("out_x", want.x, m_axis_tdata[31:0]);
		check_field("out_y", want.y, m_axis_tdata[63:32]);
		check_field("out_u", want.u, m_axis_tdata[79:64]);
		check_field("out_v", want.v, m_axis_tdata[95:80]);
		check_field("out_color", want.color, m_axis_tdata[127:96]);
		check_field("shade", want.shade, m_axis_tdata[129:128]);
		check_field("index_value", want.index, m_axis_tdata[145:130]);
		check_field("batch_offset", want.b_off, m_axis_tdata[160:146]);
		check_field("batch_count", want.b_cnt, m_axis_tdata[176:161]);
		check_field("batch_texture", want.b_tex, m_axis_tdata[192:177]);
		check_field("pad", 32'd0, m_axis_tdata[199:193]);
		check_field("last", want.last, m_axis_tlast);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat.xx        = 32'sh0001_0000;
			mat.xy        = '0;
			mat.yx        = '0;
			mat.yy        = 32'sh0001_0000;
			mat.tx        = '0;
			mat.ty        = '0;
			shade_reg     = '0;
			def_texture   = '0;
			corner        = '0;
			vcount        = 0;
			quad_base     = '0;
			open_offset   = '0;
			open_elements = '0;
			open_texture  = '0;
			dropping      = 1'b0;
			awaited_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					qvie_pkg::REG_MAT_XX:  mat.xx = cfg_data;
					qvie_pkg::REG_MAT_XY:  mat.xy = cfg_data;
					qvie_pkg::REG_MAT_YX:  mat.yx = cfg_data;
					qvie_pkg::REG_MAT_YY:  mat.yy = cfg_data;
					qvie_pkg::REG_MAT_TX:  mat.tx = cfg_data;
					qvie_pkg::REG_MAT_TY:  mat.ty = cfg_data;
					qvie_pkg::REG_SHADE:   shade_reg = cfg_data[1:0];
					qvie_pkg::REG_DEF_TEX: def_texture = cfg_data[15:0];
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_request(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready)
				compare_result();
		end
		owed_count = awaited_results.size();
	end

endmodule

/* test/tb.sv */
// top of the quad vertex index emitter testbench: clock, reset, request stimulus and verdict
module tb;

	localparam logic MODE_CORNER = ~qvie_pkg::MODE_FLUSH;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [2:0]   cfg_index = '0;
	logic [31:0]  cfg_data = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata = '0;  // pos_x, pos_y, tex_u, tex_v, color, texture
	logic [1:0]   s_axis_tuser = '0;  // mode, solid
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [199:0] m_axis_tdata;       // out_x, out_y, out_u, out_v, out_color, shade,
	                                  // index_value, batch_offset, batch_count,
	                                  // batch_texture, zero pad
	logic [1:0]   m_axis_tuser;       // kind
	logic         m_axis_tlast;

	int   owed_count;
	int   mismatches;
	// steady: neither side idles; in_random: random traffic has started
	logic steady = 1'b0;
	logic in_random = 1'b0;

	quad_vertex_index_emitter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	qvie_check i_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.owed_count    (owed_count),
		.mismatches    (mismatches)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// safety net: the slowest correct run finishes well inside this
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	// result side: random back-pressure, one long hold when random traffic
	// starts so the block fills and stalls its input
	initial begin : sink
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (in_random && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 14);
			end
		end
	end

	// request field packing, position first
	function automatic logic [143:0] corner_word(input logic [31:0] x, y, input logic [15:0] u, v,
			input logic [31:0] color, input logic [15:0] tex);
		return {tex, color, v, u, y, x};
	endfunction

	// positions: extremes, values in a modest range, or any 32-bit pattern
	function automatic logic [31:0] rand_pos();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)
			return 32'h7FFF_FFFF;
		if (pick < 10)
			return 32'h8000_0000;
		if (pick < 70)
			return $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
		return $urandom;
	endfunction

	// matrix coefficients: mostly within +-2.0, sometimes extreme or arbitrary
	function automatic logic [31:0] rand_coef();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			return 32'h7FFF_FFFF;
		if (pick < 8)
			return 32'h8000_0000;
		if (pick < 70)
			return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
		return $urandom;
	endfunction

	// a few handles repeat so batches grow across quads
	function automatic logic [15:0] pick_texture();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(1, 3);
	endfunction

	// one request, offered at a falling edge and held until taken
	task automatic send_req(input logic [143:0] d, input logic [1:0] u);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tuser  <= u;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic send_corner(input logic [31:0] x, y, input logic [15:0] u, v,
			input logic [31:0] color, input logic [15:0] tex, input logic solid);
		send_req(corner_word(x, y, u, v, color, tex), {solid, MODE_CORNER});
	endtask

	task automatic send_rand_corner(input logic [15:0] tex, input logic solid);
		send_corner(rand_pos(), rand_pos(), $urandom, $urandom, $urandom, tex, solid);
	endtask

	// flush payload is ignored by the block, so it carries noise
	task automatic send_flush();
		send_req(corner_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom),
			{1'($urandom), qvie_pkg::MODE_FLUSH});
	endtask

	// a well-formed quad; later corners pick their own solid bit
	task automatic send_quad(input logic [15:0] tex, input logic first_solid);
		send_rand_corner(tex, first_solid);
		repeat (3)
			send_rand_corner($urandom, $urandom_range(0, 3) == 0);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_setup(input logic [31:0] xx, xy, yx, yy, tx, ty,
			input logic [1:0] shade, input logic [15:0] tex);
		write_reg(qvie_pkg::REG_MAT_XX, xx);
		write_reg(qvie_pkg::REG_MAT_XY, xy);
		write_reg(qvie_pkg::REG_MAT_YX, yx);
		write_reg(qvie_pkg::REG_MAT_YY, yy);
		write_reg(qvie_pkg::REG_MAT_TX, tx);
		write_reg(qvie_pkg::REG_MAT_TY, ty);
		write_reg(qvie_pkg::REG_SHADE, shade);
		write_reg(qvie_pkg::REG_DEF_TEX, tex);
	endtask

	// stop offering, wait for every owed result, then let the pipeline go
	// quiet in case the last request produced nothing
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (owed_count != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// mostly whole quads with random content, plus flushes, abandoned
	// quads and the odd stray corner that knocks the corner count off
	task automatic random_traffic(input int target);
		int sent;
		int pick;
		int k;
		logic [15:0] tex;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				send_flush();
				sent++;
			end else if (pick < 12) begin
				k = $urandom_range(1, 3);
				tex = pick_texture();
				send_rand_corner(tex, $urandom_range(0, 3) == 0);
				repeat (k - 1)
					send_rand_corner($urandom, $urandom_range(0, 3) == 0);
				send_flush();
				sent += k + 1;
			end else if (pick < 14) begin
				send_rand_corner(pick_texture(), 1'($urandom));
				sent++;
			end else begin
				send_quad(pick_texture(), $urandom_range(0, 3) == 0);
				sent += 4;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: half-LSB coefficients for rounding ties, wash shade,
		// all-ones default texture
		load_setup(32'h0001_0000, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
			32'h0001_8000, 32'hFFFF_0000, 2'd1, 16'hFFFF);
		// textured quad at the position extremes
		send_corner(32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'h0000, 1'b0);
		send_corner(32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 16'hFFFF, 32'h0000_0000, 16'hFFFF, 1'b0);
		send_corner(32'h0000_0001, 32'hFFFF_FFFF, 16'h8001, 16'h7FFE, 32'h8000_0001, 16'h0000, 1'b0);
		send_corner(32'h0000_0000, 32'h0000_0000, 16'h1234, 16'h5678, 32'h7FFF_FFFE, 16'h0000, 1'b0);
		// same texture continues the batch; solid corners mixed in
		send_corner(32'h0000_0003, 32'h0000_0005, 16'hFFFF, 16'hFFFF, 32'h0102_0304, 16'h0000, 1'b0);
		send_corner(32'hFFFF_FFFD, 32'h0001_0001, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5, 16'h0000, 1'b1);
		send_corner(32'h0010_0001, 32'hFFF0_0001, 16'hAAAA, 16'h5555, 32'h5A5A_5A5A, 16'h0000, 1'b0);
		send_corner(32'h7FFF_0000, 32'h8001_0000, 16'h5555, 16'hAAAA, 32'hFFFF_0000, 16'h0000, 1'b1);
		// solid first corner picks the default texture and closes the batch
		send_corner(32'h0002_0000, 32'h0003_0000, 16'hFFFF, 16'hFFFF, 32'h1111_1111, 16'h1234, 1'b1);
		send_rand_corner(16'h0000, 1'b1);
		send_rand_corner(16'h0000, 1'b0);
		send_rand_corner(16'h0000, 1'b1);
		// explicit texture equal to the default keeps the batch open
		send_quad(16'hFFFF, 1'b0);
		// quad abandoned after two corners, a flush that closes its batch, then a flush with nothing open
		send_rand_corner(16'hAAAA, 1'b0);
		send_rand_corner(16'h5555, 1'b0);
		send_flush();
		send_flush();
		send_quad(16'h5555, 1'b0);
		send_flush();
		settle();

		// largest coefficients, mostly saturating results; shade 3 reads as fill
		load_setup(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 2'd3, 16'h0000);
		send_quad(16'h0001, 1'b0);
		send_quad(16'h0001, 1'b1);
		send_quad(16'h0002, 1'b0);
		send_flush();
		settle();

		// most negative coefficients, fill shade
		load_setup(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 2'd2, 16'h8001);
		send_quad(16'h0003, 1'b1);
		send_quad(16'h0003, 1'b0);
		send_quad(16'h8001, 1'b0);
		send_flush();
		settle();

		// random traffic in three settings; the middle one runs without gaps
		load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
			$urandom_range(0, 3), $urandom);
		in_random <= 1'b1;
		random_traffic(110);
		settle();
		load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
			$urandom_range(0, 3), $urandom);
		steady <= 1'b1;
		random_traffic(110);
		settle();
		steady <= 1'b0;
		load_setup(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(),
			$urandom_range(0, 3), $urandom);
		random_traffic(110);
		settle();

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
